[rtl/core/wavetable_channel_mixer_defines.svh]
// Assertion macros shared by the mixer checker.
// No dependencies.
`ifndef WAVETABLE_CHANNEL_MIXER_DEFINES_SVH
`define WAVETABLE_CHANNEL_MIXER_DEFINES_SVH

// Generic clocked assertion with synchronous active-low reset.
`define WCM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block clock and reset.
`define WCM_ASSERT_CLK(lbl, prop, msg) \
    `WCM_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

[rtl/core/wcm_pkg.sv]
// Types, codes and defaults of the wavetable channel mixer.
// Used by the top level and its checker; no dependencies.
package wcm_pkg;

    localparam int MAX_CHANNELS_DEF     = 8;
    localparam int SAMPLE_SLOTS_DEF     = 31;
    localparam int FRACTION_BITS_DEF    = 12;
    localparam int OUTPUT_BITS_DEF      = 8;
    localparam int SAMPLE_MEM_DEPTH_DEF = 131072;

    localparam logic [3:0] NUM_CH_RESET = 4'd4;
    localparam int         VOL_SHIFT    = 6;
    localparam logic [7:0] PAN_FULL     = 8'd128;
    localparam logic [7:0] PAN_HALF     = 8'd64;

    localparam logic [1:0] FUNC_GEN   = 2'd0;
    localparam logic [1:0] FUNC_CHAN  = 2'd1;
    localparam logic [1:0] FUNC_SLOT  = 2'd2;
    localparam logic [1:0] FUNC_SAMPLE = 2'd3;

    localparam logic [2:0] CH_OFFSET = 3'd0;
    localparam logic [2:0] CH_STEP   = 3'd1;
    localparam logic [2:0] CH_VOLUME = 3'd2;
    localparam logic [2:0] CH_PAN    = 3'd3;
    localparam logic [2:0] CH_SLOT   = 3'd4;

    localparam logic [2:0] SL_START    = 3'd0;
    localparam logic [2:0] SL_END      = 3'd1;
    localparam logic [2:0] SL_LOOP_LEN = 3'd2;
    localparam logic [2:0] SL_LOOP_END = 3'd3;
    localparam logic [2:0] SL_LENGTH   = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  target_index;
        logic [2:0]  field_select;
        logic [16:0] mem_address;
        logic [31:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] left_out;
        logic [7:0] right_out;
    } t_out_item;

endpackage

[rtl/core/wavetable_channel_mixer.sv]
// Wavetable channel mixer: per-channel registers, slot table and sample memory; uses wcm_pkg.
// A generate item reads each channel's slot, advances those not silent, interpolates, scales
// and pans the playing ones, divides the sums and registers the result with the strobe. A
// new item is taken once busy drops with the strobe; results cannot stall. Synchronous reset
// clears channel registers, slot-length valid bits and config; slot bounds and sample memory
// hold no reset. SAMPLE_MEM_DEPTH must be a power of two; the block does not check it.
module wavetable_channel_mixer
    import wcm_pkg::*;
#(
    parameter int MAX_CHANNELS     = MAX_CHANNELS_DEF,
    parameter int SAMPLE_SLOTS     = SAMPLE_SLOTS_DEF,
    parameter int FRACTION_BITS    = FRACTION_BITS_DEF,
    parameter int OUTPUT_BITS      = OUTPUT_BITS_DEF,
    parameter int SAMPLE_MEM_DEPTH = SAMPLE_MEM_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_item   i_item,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    output logic       o_strobe,
    output t_out_item  o_item
);

    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
    localparam int AW = $clog2(SAMPLE_MEM_DEPTH);
    localparam int FB = FRACTION_BITS;
    localparam logic [15:0] BIAS = 16'(1 << (OUTPUT_BITS - 1));

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SLOT = 9'b000000010,
        S_ADV  = 9'b000000100,
        S_SAMP = 9'b000001000,
        S_INT  = 9'b000010000,
        S_VOL  = 9'b000100000,
        S_PAN  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [3:0]  r_num_ch;
    logic [31:0] r_off  [MAX_CHANNELS];
    logic [31:0] r_step [MAX_CHANNELS];
    logic [6:0]  r_vol  [MAX_CHANNELS];
    logic [7:0]  r_pan  [MAX_CHANNELS];
    logic [4:0]  r_slot [MAX_CHANNELS];

    logic [17:0] slot_start_mem [SAMPLE_SLOTS];
    logic [17:0] slot_end_mem   [SAMPLE_SLOTS];
    logic [17:0] slot_llen_mem  [SAMPLE_SLOTS];
    logic [17:0] slot_lend_mem  [SAMPLE_SLOTS];
    logic [17:0] slot_len_mem   [SAMPLE_SLOTS];
    logic [SAMPLE_SLOTS-1:0] r_len_vld;

    logic [7:0] sample_mem [SAMPLE_MEM_DEPTH];

    logic [17:0] r_rd_start, r_rd_end, r_rd_llen, r_rd_lend, r_rd_len;
    logic        r_rd_vld;
    logic [7:0]  r_cur, r_nxt;
    logic [AW-1:0] r_pa0, r_pa1;
    logic [FB-1:0] r_frac;
    logic [CW:0]   r_ch;
    logic [15:0]   r_v, r_sum_l, r_sum_r;
    logic [15:0]   r_q_l, r_q_r;
    logic [3:0]    r_rem_l, r_rem_r;
    logic          r_neg_l, r_neg_r;
    logic [4:0]    r_cnt;

    logic          acc;
    logic [CW-1:0] ch;
    logic [SW-1:0] rd_slot;
    logic          slot_ok, silent;
    logic [31:0]   off_add, off_new, p_raw, p_new;
    logic [5:0]    n_mix;
    logic          last_ch;
    logic [3:0]    divisor;
    logic [31:0]   mem_a32;
    logic [CW-1:0] w_ch;
    logic [SW-1:0] w_sl;

    assign acc     = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign ch      = r_ch[CW-1:0];
    assign rd_slot = r_slot[ch][SW-1:0];
    assign slot_ok = (32'(r_slot[ch]) < 32'(SAMPLE_SLOTS));
    assign silent  = !slot_ok || (r_step[ch] == 32'd0) || !r_rd_vld || (r_rd_len == 18'd0);
    assign off_add = r_off[ch] + r_step[ch];
    assign p_raw   = 32'(r_rd_start) + 32'(off_add >> FB);
    assign n_mix   = (32'(r_num_ch) > 32'(MAX_CHANNELS)) ? 6'(MAX_CHANNELS) : 6'(r_num_ch);
    assign last_ch = (6'(r_ch) + 6'd1 >= n_mix);
    assign divisor = (r_num_ch == 4'd0) ? 4'd1 : r_num_ch;
    assign mem_a32 = 32'(i_item.mem_address);
    assign w_ch    = i_item.target_index[CW-1:0];
    assign w_sl    = i_item.target_index[SW-1:0];

    always_comb begin
        off_new = off_add;
        p_new   = p_raw;
        if (r_rd_llen != 18'd0) begin
            if (p_raw >= 32'(r_rd_lend)) begin
                off_new = off_add - 32'({14'd0, r_rd_llen} << FB);
                p_new   = p_raw - 32'(r_rd_llen);
            end
        end else if (p_raw >= 32'(r_rd_end)) begin
            p_new = 32'(r_rd_end);
        end
    end

    // Channel registers: host writes when idle, offset/step write-back in S_ADV.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_off[i]  <= '0;
                r_step[i] <= '0;
                r_vol[i]  <= '0;
                r_pan[i]  <= '0;
                r_slot[i] <= '0;
            end
        end else if (acc && i_item.func == FUNC_CHAN
                     && 32'(i_item.target_index) < 32'(MAX_CHANNELS)) begin
            unique case (i_item.field_select)
                CH_OFFSET: r_off[w_ch]  <= i_item.write_value;
                CH_STEP:   r_step[w_ch] <= i_item.write_value;
                CH_VOLUME: r_vol[w_ch]  <= i_item.write_value[6:0];
                CH_PAN:    r_pan[w_ch]  <= i_item.write_value[7:0];
                CH_SLOT:   r_slot[w_ch] <= i_item.write_value[4:0];
                default: ;
            endcase
        end else if (r_state == S_ADV && !silent) begin
            // A muted channel only advances; no loop wrap and no end stop.
            if (r_vol[ch] == 7'd0) begin
                r_off[ch] <= off_add;
            end else begin
                r_off[ch] <= off_new;
                if (r_rd_llen == 18'd0 && p_raw >= 32'(r_rd_end)) begin
                    r_step[ch] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
            r_num_ch  <= NUM_CH_RESET;
        end else begin
            if (i_cfg_we) begin
                r_num_ch <= i_cfg_wdata;
            end
            if (acc && i_item.func == FUNC_SLOT && i_item.field_select == SL_LENGTH
                && 32'(i_item.target_index) < 32'(SAMPLE_SLOTS)) begin
                r_len_vld[w_sl] <= 1'b1;
            end
        end
    end

    // Slot table memory: one write port per field, registered read.
    always_ff @(posedge i_clk) begin
        if (acc && i_item.func == FUNC_SLOT && 32'(i_item.target_index) < 32'(SAMPLE_SLOTS)) begin
            unique case (i_item.field_select)
                SL_START:    slot_start_mem[w_sl] <= i_item.write_value[17:0];
                SL_END:      slot_end_mem[w_sl]   <= i_item.write_value[17:0];
                SL_LOOP_LEN: slot_llen_mem[w_sl]  <= i_item.write_value[17:0];
                SL_LOOP_END: slot_lend_mem[w_sl]  <= i_item.write_value[17:0];
                SL_LENGTH:   slot_len_mem[w_sl]   <= i_item.write_value[17:0];
                default: ;
            endcase
        end
        r_rd_start <= slot_start_mem[rd_slot];
        r_rd_end   <= slot_end_mem[rd_slot];
        r_rd_llen  <= slot_llen_mem[rd_slot];
        r_rd_lend  <= slot_lend_mem[rd_slot];
        r_rd_len   <= slot_len_mem[rd_slot];
        r_rd_vld   <= r_len_vld[rd_slot];
    end

    // Sample memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (acc && i_item.func == FUNC_SAMPLE) begin
            sample_mem[mem_a32[AW-1:0]] <= i_item.write_value[7:0];
        end
        r_cur <= sample_mem[r_pa0];
        r_nxt <= sample_mem[r_pa1];
    end

    // Datapath arithmetic.
    logic signed [8:0]       diff;
    logic signed [FB+10:0]   interp;
    logic signed [31:0]      v_int;
    logic signed [23:0]      v_vol;
    logic signed [8:0]       wl;
    logic signed [8:0]       wr;
    logic signed [24:0]      prod_l, prod_r;
    logic [4:0]              sh_l, sh_r;

    always_comb begin
        diff   = 9'(signed'(r_nxt)) - 9'(signed'(r_cur));
        interp = (FB + 11)'(diff * signed'({1'b0, r_frac})) >>> FB;
        v_int  = (32'(signed'(r_cur)) + 32'(interp)) <<< (OUTPUT_BITS - 8);
        v_vol  = (signed'(r_v) * signed'({1'b0, r_vol[ch]})) >>> VOL_SHIFT;
        wl     = signed'({1'b0, PAN_FULL}) - signed'({1'b0, r_pan[ch]});
        if (wl > signed'({1'b0, PAN_HALF})) begin
            wl = signed'({1'b0, PAN_HALF});
        end
        wr     = (r_pan[ch] > PAN_HALF) ? signed'({1'b0, PAN_HALF})
                                        : signed'({1'b0, r_pan[ch]});
        prod_l = (signed'(r_v) * wl) >>> VOL_SHIFT;
        prod_r = (signed'(r_v) * wr) >>> VOL_SHIFT;
        sh_l   = {r_rem_l, r_q_l[15]};
        sh_r   = {r_rem_r, r_q_r[15]};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (acc && i_item.func == FUNC_GEN) begin
                n_state = (n_mix == 6'd0) ? S_DIV : S_SLOT;
            end
            S_SLOT: n_state = S_ADV;
            S_ADV: begin
                if (silent || r_vol[ch] == 7'd0) begin
                    n_state = last_ch ? S_DIV : S_SLOT;
                end else begin
                    n_state = S_SAMP;
                end
            end
            S_SAMP: n_state = S_INT;
            S_INT:  n_state = S_VOL;
            S_VOL:  n_state = S_PAN;
            S_PAN:  n_state = last_ch ? S_DIV : S_SLOT;
            S_DIV:  if (r_cnt == 5'd16) begin
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
            r_ch     <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == S_DONE);
            if (r_state == S_IDLE) begin
                r_ch  <= '0;
                r_cnt <= '0;
            end else if ((r_state == S_ADV && n_state == S_SLOT)
                         || (r_state == S_PAN && n_state == S_SLOT)) begin
                r_ch <= r_ch + 1'b1;
            end
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_sum_l <= '0;
                r_sum_r <= '0;
            end
            S_ADV: begin
                r_pa0  <= p_new[AW-1:0];
                r_pa1  <= AW'(p_new + 32'd1);
                r_frac <= off_new[FB-1:0];
            end
            S_INT: r_v <= v_int[15:0];
            S_VOL: r_v <= v_vol[15:0];
            S_PAN: begin
                r_sum_l <= r_sum_l + prod_l[15:0];
                r_sum_r <= r_sum_r + prod_r[15:0];
            end
            S_DIV: begin
                if (r_cnt == 5'd0) begin
                    // Load magnitudes; restoring steps follow.
                    r_neg_l <= r_sum_l[15];
                    r_neg_r <= r_sum_r[15];
                    r_q_l   <= r_sum_l[15] ? -r_sum_l : r_sum_l;
                    r_q_r   <= r_sum_r[15] ? -r_sum_r : r_sum_r;
                    r_rem_l <= '0;
                    r_rem_r <= '0;
                end else begin
                    if (sh_l >= {1'b0, divisor}) begin
                        r_rem_l <= 4'(sh_l - {1'b0, divisor});
                        r_q_l   <= {r_q_l[14:0], 1'b1};
                    end else begin
                        r_rem_l <= sh_l[3:0];
                        r_q_l   <= {r_q_l[14:0], 1'b0};
                    end
                    if (sh_r >= {1'b0, divisor}) begin
                        r_rem_r <= 4'(sh_r - {1'b0, divisor});
                        r_q_r   <= {r_q_r[14:0], 1'b1};
                    end else begin
                        r_rem_r <= sh_r[3:0];
                        r_q_r   <= {r_q_r[14:0], 1'b0};
                    end
                end
            end
            S_DONE: begin
                o_item.left_out  <= 8'((r_neg_l ? -r_q_l : r_q_l) + BIAS);
                o_item.right_out <= 8'((r_neg_r ? -r_q_r : r_q_r) + BIAS);
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/wcm_checker.sv]
// Port-level checker for the wavetable channel mixer, with its bind.
// Depends on wcm_pkg and wavetable_channel_mixer_defines.svh.
`include "wavetable_channel_mixer_defines.svh"

module wcm_checker
    import wcm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_strobe
);

    `WCM_ASSERT_CLK(a_gen_busy, start && !busy && i_item.func == FUNC_GEN |=> busy, "generate item did not raise busy")
    `WCM_ASSERT_CLK(a_wr_quiet, start && !busy && i_item.func != FUNC_GEN |=> !busy && !o_strobe, "write item caused work")
    `WCM_ASSERT_CLK(a_strobe_src, o_strobe |-> $past(busy) && !busy, "result without a generate item")
    `WCM_ASSERT_CLK(a_strobe_one, o_strobe |=> !o_strobe, "result held longer than one cycle")

endmodule

bind wavetable_channel_mixer wcm_checker u_wcm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe)
);

[sim/tb.sv]
// Self-checking testbench for wavetable_channel_mixer: random and directed
// write/generate items, mixed output predicted in SV. Depends on wcm_pkg.
module tb;
    import wcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH   = 8;
    localparam int NSLOT = 31;
    localparam int DEPTH = 131072;
    localparam int DRAIN = 100;
    localparam int WDOG  = 5000;
    localparam int IW    = $bits(t_in_item);

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = '0;
    logic      o_strobe;
    t_out_item o_item;

    wavetable_channel_mixer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_strobe(o_strobe), .o_item(o_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Two copies of the mixer state: [0] tracks items as queued, [1] as accepted.
    logic [31:0] ch_off  [2][NCH];
    logic [31:0] ch_step [2][NCH];
    logic [6:0]  ch_vol  [2][NCH];
    logic [7:0]  ch_pan  [2][NCH];
    logic [4:0]  ch_slot [2][NCH];
    logic [17:0] slot_tab[2][NSLOT][5];
    logic [7:0]  smem    [2][DEPTH];
    logic [3:0]  nch     [2];
    bit          slot_set[NSLOT][5];
    bit          byte_set[DEPTH];

    t_in_item  item_q[$];
    t_out_item mix_expect[$];
    int        idle_pct = 0;
    int        errors = 0;
    int        quiet = 0;

    function automatic int w16(input int v);
        logic signed [15:0] t;
        t = v[15:0];
        return int'(t);
    endfunction

    function automatic int sbyte(input logic [7:0] b);
        return int'($signed(b));
    endfunction

    function automatic void mix_channel(input int m, input int c, inout int sl, inout int sr);
        logic [4:0]  s;
        logic [31:0] p;
        logic [31:0] q;
        int cur, nxt, v, wl, wr, frac;
        s = ch_slot[m][c];
        if (s >= NSLOT) return;
        if (ch_step[m][c] == 0 || slot_tab[m][s][SL_LENGTH] == 0) return;
        ch_off[m][c] += ch_step[m][c];
        if (ch_vol[m][c] == 0) return;
        p = 32'(slot_tab[m][s][SL_START]) + (ch_off[m][c] >> 12);
        if (slot_tab[m][s][SL_LOOP_LEN] != 0) begin
            if (p >= 32'(slot_tab[m][s][SL_LOOP_END])) begin
                ch_off[m][c] -= 32'(slot_tab[m][s][SL_LOOP_LEN]) << 12;
                p -= 32'(slot_tab[m][s][SL_LOOP_LEN]);
            end
        end else if (p >= 32'(slot_tab[m][s][SL_END])) begin
            ch_step[m][c] = '0;
            p = 32'(slot_tab[m][s][SL_END]);
        end
        q = p + 1;
        cur = sbyte(smem[m][p[16:0]]);
        nxt = sbyte(smem[m][q[16:0]]);
        frac = int'(ch_off[m][c][11:0]);
        v = w16(cur + (((nxt - cur) * frac) >>> 12));
        v = w16((v * int'(ch_vol[m][c])) >>> VOL_SHIFT);
        wl = 128 - int'(ch_pan[m][c]);
        if (wl > 64) wl = 64;
        wr = (ch_pan[m][c] > 64) ? 64 : int'(ch_pan[m][c]);
        sl = w16(sl + ((v * wl) >>> VOL_SHIFT));
        sr = w16(sr + ((v * wr) >>> VOL_SHIFT));
    endfunction

    // Apply one item to copy m; return 1 with the mixed sample for a generate.
    function automatic bit mixer_step(input int m, input t_in_item it, output t_out_item o);
        int sl, sr, dv, n;
        logic [4:0] idx;
        o = '0;
        sl = 0;
        sr = 0;
        idx = it.target_index;
        case (it.func)
            FUNC_CHAN: begin
                if (idx < NCH) begin
                    case (it.field_select)
                        CH_OFFSET: ch_off[m][idx] = it.write_value;
                        CH_STEP:   ch_step[m][idx] = it.write_value;
                        CH_VOLUME: ch_vol[m][idx] = it.write_value[6:0];
                        CH_PAN:    ch_pan[m][idx] = it.write_value[7:0];
                        CH_SLOT:   ch_slot[m][idx] = it.write_value[4:0];
                        default: ;
                    endcase
                end
            end
            FUNC_SLOT: begin
                if (idx < NSLOT && it.field_select <= SL_LENGTH)
                    slot_tab[m][idx][it.field_select] = it.write_value[17:0];
            end
            FUNC_SAMPLE: smem[m][it.mem_address] = it.write_value[7:0];
            default: begin
                n = (nch[m] > NCH) ? NCH : int'(nch[m]);
                for (int c = 0; c < n; c++) mix_channel(m, c, sl, sr);
                dv = (nch[m] == 0) ? 1 : int'(nch[m]);
                sl = w16(sl / dv);
                sr = w16(sr / dv);
                o.left_out = 8'(sl + 128);
                o.right_out = 8'(sr + 128);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_in_item mk(input logic [1:0] f, input logic [4:0] idx,
                                    input logic [2:0] sel, input logic [16:0] a,
                                    input logic [31:0] val);
        t_in_item t;
        t.func = f;
        t.target_index = idx;
        t.field_select = sel;
        t.mem_address = a;
        t.write_value = val;
        return t;
    endfunction

    function automatic void push_item(input t_in_item t);
        t_out_item dummy;
        void'(mixer_step(0, t, dummy));
        if (t.func == FUNC_SLOT && t.target_index < NSLOT && t.field_select <= SL_LENGTH)
            slot_set[t.target_index][t.field_select] = 1'b1;
        if (t.func == FUNC_SAMPLE) byte_set[t.mem_address] = 1'b1;
        item_q.push_back(t);
    endfunction

    // Find a slot bound or sample byte that the next generate would read unwritten.
    function automatic bit find_hole(output t_in_item f);
        logic [4:0]  s;
        logic [31:0] off, p, q;
        int n;
        n = (nch[0] > NCH) ? NCH : int'(nch[0]);
        for (int c = 0; c < n; c++) begin
            s = ch_slot[0][c];
            if (s >= NSLOT || ch_step[0][c] == 0 || slot_tab[0][s][SL_LENGTH] == 0
                || ch_vol[0][c] == 0) continue;
            if (!slot_set[s][SL_START]) begin
                f = mk(FUNC_SLOT, s, SL_START, '0, $urandom_range(0, 1500));
                return 1'b1;
            end
            if (!slot_set[s][SL_LOOP_LEN]) begin
                f = mk(FUNC_SLOT, s, SL_LOOP_LEN, '0,
                       $urandom_range(1) ? 0 : $urandom_range(1, 100));
                return 1'b1;
            end
            if (slot_tab[0][s][SL_LOOP_LEN] != 0 && !slot_set[s][SL_LOOP_END]) begin
                f = mk(FUNC_SLOT, s, SL_LOOP_END, '0, $urandom_range(0, 2000));
                return 1'b1;
            end
            if (slot_tab[0][s][SL_LOOP_LEN] == 0 && !slot_set[s][SL_END]) begin
                f = mk(FUNC_SLOT, s, SL_END, '0, $urandom_range(0, 2000));
                return 1'b1;
            end
            off = ch_off[0][c] + ch_step[0][c];
            p = 32'(slot_tab[0][s][SL_START]) + (off >> 12);
            if (slot_tab[0][s][SL_LOOP_LEN] != 0) begin
                if (p >= 32'(slot_tab[0][s][SL_LOOP_END])) p -= 32'(slot_tab[0][s][SL_LOOP_LEN]);
            end else if (p >= 32'(slot_tab[0][s][SL_END])) begin
                p = 32'(slot_tab[0][s][SL_END]);
            end
            q = p + 1;
            if (!byte_set[p[16:0]]) begin
                f = mk(FUNC_SAMPLE, '0, '0, p[16:0], $urandom);
                return 1'b1;
            end
            if (!byte_set[q[16:0]]) begin
                f = mk(FUNC_SAMPLE, '0, '0, q[16:0], $urandom);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void push_gen();
        t_in_item f;
        while (find_hole(f)) push_item(f);
        push_item(mk(FUNC_GEN, 5'($urandom), 3'($urandom), 17'($urandom), $urandom));
    endfunction

    function automatic void rand_action();
        int r;
        logic [2:0] sel;
        logic [31:0] val;
        t_in_item t;
        r = $urandom_range(99);
        if (r < 45) begin
            push_gen();
        end else if (r < 60) begin
            sel = 3'($urandom_range(CH_OFFSET, CH_SLOT));
            case (sel)
                CH_OFFSET: val = $urandom_range(0, 32'h7FFFF);
                CH_STEP:   val = ($urandom_range(9) == 0) ? $urandom
                                 : ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 32'h3000);
                CH_VOLUME: val = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 64);
                CH_PAN:    val = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 128);
                default:   val = ($urandom_range(9) == 0) ? $urandom_range(29, 31)
                                 : $urandom_range(0, 5);
            endcase
            push_item(mk(FUNC_CHAN, 5'($urandom_range(0, NCH - 1)), sel, 17'($urandom), val));
        end else if (r < 70) begin
            sel = 3'($urandom_range(SL_START, SL_LENGTH));
            case (sel)
                SL_LOOP_LEN: val = $urandom_range(1) ? 0 : $urandom_range(1, 200);
                SL_LENGTH:   val = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 2000);
                default:     val = $urandom_range(0, 2000);
            endcase
            push_item(mk(FUNC_SLOT, 5'($urandom_range(0, 5)), sel, 17'($urandom), val));
        end else if (r < 85) begin
            push_item(mk(FUNC_SAMPLE, 5'($urandom), 3'($urandom),
                          17'($urandom_range(0, 2300)), $urandom));
        end else begin
            t = t_in_item'(IW'({$urandom, $urandom}));
            if (t.func == FUNC_GEN) push_gen();
            else push_item(t);
        end
    endfunction

    // Driver: hold an item on the port until it is taken.
    always @(posedge i_clk) begin
        t_out_item o;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (mixer_step(1, i_item, o)) mix_expect.push_back(o);
            end
            if (!start || !busy) begin
                if (item_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_item <= item_q.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) quiet <= 0;
            else quiet <= quiet + 1;
            if (o_strobe) begin
                if (mix_expect.size() == 0) begin
                    $display("%0t: unexpected result L=%0d R=%0d", $time,
                             o_item.left_out, o_item.right_out);
                    errors <= errors + 1;
                end else begin
                    e = mix_expect.pop_front();
                    if (o_item.left_out !== e.left_out || o_item.right_out !== e.right_out) begin
                        $display("%0t: mismatch expected L=%0d R=%0d actual L=%0d R=%0d", $time,
                                 e.left_out, e.right_out, o_item.left_out, o_item.right_out);
                        errors <= errors + 1;
                    end
                end
            end
            if (quiet >= WDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (item_q.size() != 0 || start || mix_expect.size() != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [3:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        nch[0] = v;
        nch[1] = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int cfgs[6];
        int idles[6];
        cfgs = '{8, 15, 1, 0, 6, 8};
        idles = '{14, 14, 83, 83, 0, 0};
        for (int m = 0; m < 2; m++) begin
            nch[m] = NUM_CH_RESET;
            for (int c = 0; c < NCH; c++) begin
                ch_off[m][c] = '0; ch_step[m][c] = '0; ch_vol[m][c] = '0;
                ch_pan[m][c] = '0; ch_slot[m][c] = '0;
            end
            for (int s = 0; s < NSLOT; s++)
                for (int k = 0; k < 5; k++) slot_tab[m][s][k] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: sample extremes, end clamp, looping, ignored writes, silent slot.
        idle_pct = 14;
        push_item(mk(FUNC_SAMPLE, '0, '0, 17'd0, 32'h80));
        push_item(mk(FUNC_SAMPLE, '0, '0, 17'd1, 32'h7F));
        push_item(mk(FUNC_SAMPLE, '0, '0, 17'h1FFFF, 32'hFFFF_FFFF));
        push_item(mk(FUNC_SLOT, 5'd0, SL_START, '0, 32'd0));
        push_item(mk(FUNC_SLOT, 5'd0, SL_END, '0, 32'd2));
        push_item(mk(FUNC_SLOT, 5'd0, SL_LOOP_LEN, '0, 32'd0));
        push_item(mk(FUNC_SLOT, 5'd0, SL_LENGTH, '0, 32'hFFFF_FFFF));
        push_item(mk(FUNC_SLOT, 5'd30, SL_START, '0, 32'd4));
        push_item(mk(FUNC_SLOT, 5'd30, SL_LOOP_LEN, '0, 32'd2));
        push_item(mk(FUNC_SLOT, 5'd30, SL_LOOP_END, '0, 32'd8));
        push_item(mk(FUNC_SLOT, 5'd30, SL_LENGTH, '0, 32'd1));
        push_item(mk(FUNC_SLOT, 5'd31, SL_LENGTH, '0, 32'd0));
        push_item(mk(FUNC_CHAN, 5'd0, CH_STEP, '0, 32'h1800));
        push_item(mk(FUNC_CHAN, 5'd0, CH_VOLUME, '0, 32'd64));
        push_item(mk(FUNC_CHAN, 5'd1, CH_SLOT, '0, 32'd30));
        push_item(mk(FUNC_CHAN, 5'd1, CH_STEP, '0, 32'h0C00));
        push_item(mk(FUNC_CHAN, 5'd1, CH_VOLUME, '0, 32'd127));
        push_item(mk(FUNC_CHAN, 5'd1, CH_PAN, '0, 32'd255));
        push_item(mk(FUNC_CHAN, 5'd2, CH_SLOT, '0, 32'd31));
        push_item(mk(FUNC_CHAN, 5'd2, CH_STEP, '0, 32'hFFFF_FFFF));
        push_item(mk(FUNC_CHAN, 5'd31, CH_VOLUME, '0, 32'd64));
        push_item(mk(FUNC_CHAN, 5'd0, 3'd7, '0, 32'd5));
        repeat (4) push_gen();
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(4'(cfgs[ph]));
            idle_pct = idles[ph];
            repeat (310) rand_action();
            wait_idle();
        end

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/wcm_pkg.sv
rtl/core/wavetable_channel_mixer.sv
rtl/core/wcm_checker.sv
sim/tb.sv
